FILE: src/nparc_pkg.sv
// Shared types and codes for the noise-aware pixel recolor block.
`default_nettype none
package nparc_pkg;

  localparam int LEVEL_W = 8;
  localparam int BOUND_W = LEVEL_W + 1;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_SET_MAP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_LUT_BASE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BINOCULAR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_OCCLUDE   = 3'd4;

  // Noise band bounds and occlusion flag as seen by the item path.
  typedef struct packed {
    logic               occlude;
    logic [BOUND_W-1:0] lo_bound;
    logic [BOUND_W-1:0] hi_bound;
  } cfg_t;

  // One access to the color map when en is set: read always, write when wr is set.
  typedef struct packed {
    logic               en;
    logic               wr;
    logic [LEVEL_W-1:0] key_level;
    logic [LEVEL_W-1:0] data;
  } map_req_t;

endpackage
`default_nettype wire

FILE: src/nparc_cfg.sv
// Register file for the noise band and occlusion settings.
`default_nettype none
module nparc_cfg #(
  parameter int BAND_LEVELS = 100
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [nparc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [nparc_pkg::CFG_DATA_W-1:0]  wr_data,
  output nparc_pkg::cfg_t                      cfg
);
  import nparc_pkg::*;

  localparam logic [LEVEL_W-1:0] BAND = LEVEL_W'(BAND_LEVELS);

  logic [LEVEL_W-1:0] lut_base, lut_base_next;
  logic [6:0]         bino, bino_next;
  logic [6:0]         left_pct, left_pct_next;
  logic [6:0]         right_pct, right_pct_next;
  logic               occlude, occlude_next;
  logic [BOUND_W-1:0] lo_bound, lo_bound_next;
  logic [BOUND_W-1:0] hi_bound, hi_bound_next;

  logic [LEVEL_W-1:0] sat_b, sat_l, sat_r;
  logic [9:0]         pct_sum;
  logic [LEVEL_W-1:0] share;

  function automatic logic [LEVEL_W-1:0] sat_pct(input logic [6:0] p);
    logic [LEVEL_W-1:0] pw;
    pw = {1'b0, p};
    return (pw > BAND) ? BAND : pw;
  endfunction

  always_comb begin
    lut_base_next  = lut_base;
    bino_next      = bino;
    left_pct_next  = left_pct;
    right_pct_next = right_pct;
    occlude_next   = occlude;
    if (wr_en) begin
      unique case (wr_index)
        CFG_LUT_BASE:  lut_base_next  = wr_data;
        CFG_BINOCULAR: bino_next      = wr_data[6:0];
        CFG_LEFT:      left_pct_next  = wr_data[6:0];
        CFG_RIGHT:     right_pct_next = wr_data[6:0];
        CFG_OCCLUDE:   occlude_next   = wr_data[0];
        default:       ;
      endcase
    end
    // Bounds follow the new register values in the same edge.
    sat_b   = sat_pct(bino_next);
    sat_l   = sat_pct(left_pct_next);
    sat_r   = sat_pct(right_pct_next);
    pct_sum = 10'(sat_b) + 10'(sat_l) + 10'(sat_r);
    share   = (pct_sum >= 10'(BAND)) ? '0 : LEVEL_W'(10'(BAND) - pct_sum);
    lo_bound_next = BOUND_W'(lut_base_next) + BOUND_W'(share);
    hi_bound_next = BOUND_W'(lut_base_next) + BOUND_W'(BAND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lut_base  <= '0;
      bino      <= '0;
      left_pct  <= '0;
      right_pct <= '0;
      occlude   <= 1'b0;
      lo_bound  <= BOUND_W'(BAND);
      hi_bound  <= BOUND_W'(BAND);
    end else begin
      lut_base  <= lut_base_next;
      bino      <= bino_next;
      left_pct  <= left_pct_next;
      right_pct <= right_pct_next;
      occlude   <= occlude_next;
      lo_bound  <= lo_bound_next;
      hi_bound  <= hi_bound_next;
    end
  end

  assign cfg.occlude  = occlude;
  assign cfg.lo_bound = lo_bound;
  assign cfg.hi_bound = hi_bound;

endmodule
`default_nettype wire

FILE: src/nparc_map_mem.sv
// Color map: entry memory with registered read and per-key valid flags.
`default_nettype none
module nparc_map_mem #(
  parameter int LEVEL_COUNT = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nparc_pkg::map_req_t         req,
  output logic [nparc_pkg::LEVEL_W-1:0]    rd_data,
  output logic                             rd_valid
);
  import nparc_pkg::*;

  localparam int LEVEL_RANGE = 1 << LEVEL_W;
  localparam int KEY_W = $clog2(LEVEL_COUNT);
  // Keys come from 8-bit levels, so at most LEVEL_RANGE entries are reachable.
  localparam int VALID_DEPTH = (LEVEL_COUNT < LEVEL_RANGE) ? LEVEL_COUNT : LEVEL_RANGE;
  localparam int VALID_W = $clog2(VALID_DEPTH);

  logic [LEVEL_W-1:0] mem [LEVEL_COUNT];
  logic [VALID_DEPTH-1:0] valid;
  logic [KEY_W-1:0] key_table [LEVEL_RANGE];
  logic [KEY_W-1:0] key;

  // Level to key reduction, fixed at elaboration.
  for (genvar g = 0; g < LEVEL_RANGE; g++) begin : g_key
    assign key_table[g] = KEY_W'(g % LEVEL_COUNT);
  end

  assign key = key_table[req.key_level];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.wr) begin
        mem[key] <= req.data;
      end
      rd_data  <= mem[key];
      rd_valid <= valid[key[VALID_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.en && req.wr) begin
      valid[key[VALID_W-1:0]] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: src/noise_aware_pixel_recolor_top.sv
// Top level of the noise-aware pixel recolor block.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | command fg_level map_value alt_level
//          |                      | fb_level saved_level
//  out     | out_valid / out_ready| level write_pixel tested_noise
//  cfg     | cfg_valid / cfg_ready| cfg_index cfg_data
//
// Each item passes the map read on accept, then the result register.
// A new item enters every cycle unless the output stalls; the map read
// is registered. Map writes land at the accept edge, so the next item
// reads them. Reset clears the map valid flags at once. A stalled output
// holds the stage behind it and then the input.
`default_nettype none
module noise_aware_pixel_recolor_top #(
  parameter int LEVEL_COUNT = 256,
  parameter int BAND_LEVELS = 100
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [nparc_pkg::CMD_W-1:0]       command,
  input  wire logic [nparc_pkg::LEVEL_W-1:0]     fg_level,
  input  wire logic [nparc_pkg::LEVEL_W-1:0]     map_value,
  input  wire logic [nparc_pkg::LEVEL_W-1:0]     alt_level,
  input  wire logic [nparc_pkg::LEVEL_W-1:0]     fb_level,
  input  wire logic [nparc_pkg::LEVEL_W-1:0]     saved_level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [nparc_pkg::LEVEL_W-1:0]          level,
  output logic                                   write_pixel,
  output logic                                   tested_noise,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nparc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [nparc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nparc_pkg::*;

  cfg_t     cfg;
  map_req_t map_req;

  logic               in_fire;
  logic               out_free;
  logic               s1_move;
  logic [LEVEL_W-1:0] test_level;
  logic               is_noise;
  logic               tested;

  logic               s1_valid;
  logic [CMD_W-1:0]   s1_cmd;
  logic [LEVEL_W-1:0] s1_fg;
  logic [LEVEL_W-1:0] s1_alt;
  logic [LEVEL_W-1:0] s1_saved;
  logic               s1_tested;
  logic [LEVEL_W-1:0] map_data;
  logic               map_hit;

  logic [LEVEL_W-1:0] res_level;
  logic               res_write;

  assign cfg_ready = 1'b1;

  nparc_cfg #(
    .BAND_LEVELS(BAND_LEVELS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_valid),
    .wr_index(cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign in_fire  = in_valid && in_ready;

  // Restore keys the map by the framebuffer level and tests the saved copy.
  assign test_level = (command == CMD_RESTORE) ? saved_level : fb_level;
  assign is_noise   = ({1'b0, test_level} >= cfg.lo_bound) &&
                      ({1'b0, test_level} < cfg.hi_bound);

  always_comb begin
    case (command)
      CMD_SET_MAP: tested = 1'b0;
      CMD_DRAW:    tested = is_noise && !cfg.occlude;
      default:     tested = is_noise;
    endcase
  end

  assign map_req.en        = in_fire;
  assign map_req.wr        = (command == CMD_SET_MAP);
  assign map_req.key_level = (command == CMD_RESTORE) ? fb_level : fg_level;
  assign map_req.data      = map_value;

  nparc_map_mem #(
    .LEVEL_COUNT(LEVEL_COUNT)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_data (map_data),
    .rd_valid(map_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd    <= command;
      s1_fg     <= fg_level;
      s1_alt    <= alt_level;
      s1_saved  <= saved_level;
      s1_tested <= tested;
    end
  end

  always_comb begin
    res_level = '0;
    res_write = 1'b0;
    case (s1_cmd)
      CMD_SET_MAP: begin
        res_level = '0;
        res_write = 1'b0;
      end
      CMD_DRAW: begin
        res_level = s1_tested ? s1_alt : s1_fg;
        res_write = 1'b1;
      end
      CMD_GET: begin
        res_level = (s1_tested && map_hit) ? map_data : s1_fg;
        res_write = 1'b0;
      end
      default: begin
        if (!map_hit) begin
          res_level = s1_saved;
          res_write = 1'b1;
        end else if (s1_tested) begin
          res_level = map_data;
          res_write = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      level        <= res_level;
      write_pixel  <= res_write;
      tested_noise <= s1_tested;
    end
  end

endmodule
`default_nettype wire
